>>> src/b62e_pkg.sv
// Shared types, constants and helpers for the base-62 integer encoder.
package b62e_pkg;

  localparam logic [7:0]  BUF_LEN_RESET  = 8'd64;
  localparam int          QUEUE_DEPTH_DEF = 2;
  localparam int          VALUE_W        = 32;
  localparam int          MAX_DIGITS     = 6;
  localparam int          DIG_CNT_W      = 3;
  localparam int          CHAR_CNT_W     = 4;
  localparam logic [5:0]  RADIX          = 6'd62;
  // x / 31 == (x * RECIP_31) >> RECIP_SHIFT for x < 2^31
  localparam logic [31:0] RECIP_31       = 32'd2216757315;
  localparam int          RECIP_SHIFT    = 36;
  localparam int          PROD_W         = 63;
  localparam logic [7:0]  CHAR_MINUS     = 8'h2d;
  localparam logic [7:0]  CHAR_NUL       = 8'h00;

  typedef struct packed {
    logic                 neg;
    logic [VALUE_W-1:0]   mag;
  } q_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CORR,
    S_CHECK,
    S_SIGN,
    S_DIGIT,
    S_ERR
  } back_state_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    if (d < 6'd10) begin
      c = 8'h30 + {2'b00, d};
    end else if (d < 6'd36) begin
      c = 8'h61 + {2'b00, d} - 8'd10;
    end else begin
      c = 8'h41 + {2'b00, d} - 8'd36;
    end
    return c;
  endfunction

endpackage

>>> src/b62e_front.sv
// Front end: accepts input transactions, splits sign and magnitude, feeds the queue.
module b62e_front (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [31:0]              value,
  output logic                     push,
  output b62e_pkg::q_entry_t       entry,
  input  logic                     full
);
  import b62e_pkg::*;

  assign in_stall  = full;
  assign push      = in_valid && !full;
  assign entry.neg = value[VALUE_W-1];
  // most negative value wraps to 2^31, read as unsigned
  assign entry.mag = value[VALUE_W-1] ? (~value + 32'd1) : value;

endmodule

>>> src/b62e_queue.sv
// Small FIFO between front end and conversion back end.
module b62e_queue #(
  parameter int DEPTH = b62e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  b62e_pkg::q_entry_t   wr_data,
  output logic                 full,
  input  logic                 pop,
  output b62e_pkg::q_entry_t   rd_data,
  output logic                 empty
);
  import b62e_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_entry_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/b62e_back.sv
// Back end: digit extraction by reciprocal multiply, capacity check, character output.
module b62e_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  b62e_pkg::q_entry_t   rd_data,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           text_char,
  output logic                 last,
  output logic                 overflow
);
  import b62e_pkg::*;

  back_state_t           state;
  back_state_t           state_next;
  logic [7:0]            buffer_length;
  logic                  neg;
  logic [VALUE_W-1:0]    cur;
  logic [PROD_W-1:0]     prod;
  logic [5:0]            digits [MAX_DIGITS];
  logic [DIG_CNT_W-1:0]  ndig;
  logic [DIG_CNT_W-1:0]  idx;

  logic [VALUE_W-1:0]    q_est;
  logic [VALUE_W-1:0]    r_est;
  logic [VALUE_W-1:0]    q_fix;
  logic [5:0]            r_fix;
  logic [CHAR_CNT_W-1:0] char_cnt;
  logic                  too_long;
  logic                  slot_free;
  logic                  out_load;
  logic [7:0]            char_next;
  logic                  last_next;
  logic                  ovf_next;

  assign slot_free = !out_valid || !out_stall;

  assign q_est = VALUE_W'(prod[PROD_W-1:RECIP_SHIFT]);
  assign r_est = cur - {q_est[VALUE_W-7:0], 6'b0} + {q_est[VALUE_W-2:0], 1'b0};
  always_comb begin
    if (r_est >= VALUE_W'(RADIX)) begin
      q_fix = q_est + 1'b1;
      r_fix = 6'(r_est - VALUE_W'(RADIX));
    end else begin
      q_fix = q_est;
      r_fix = r_est[5:0];
    end
  end

  assign char_cnt = CHAR_CNT_W'(ndig) + CHAR_CNT_W'(neg);
  // single-digit results skip the capacity check
  assign too_long = (ndig != DIG_CNT_W'(1)) && ({4'b0, char_cnt} >= buffer_length);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (!empty) state_next = S_MUL;
      S_MUL:   state_next = S_CORR;
      S_CORR:  state_next = (q_fix == '0) ? S_CHECK : S_MUL;
      S_CHECK: begin
        priority if (too_long) state_next = S_ERR;
        else if (neg)          state_next = S_SIGN;
        else                   state_next = S_DIGIT;
      end
      S_SIGN:  if (slot_free) state_next = S_DIGIT;
      S_DIGIT: if (slot_free && idx == '0) state_next = S_IDLE;
      S_ERR:   if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    out_load  = 1'b0;
    char_next = CHAR_NUL;
    last_next = 1'b0;
    ovf_next  = 1'b0;
    unique case (state)
      S_IDLE:  pop = !empty;
      S_SIGN: begin
        out_load  = slot_free;
        char_next = CHAR_MINUS;
      end
      S_DIGIT: begin
        out_load  = slot_free;
        char_next = digit_char(digits[idx]);
        last_next = (idx == '0);
      end
      S_ERR: begin
        out_load  = slot_free;
        last_next = 1'b1;
        ovf_next  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      buffer_length <= BUF_LEN_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        buffer_length <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      neg  <= rd_data.neg;
      cur  <= rd_data.mag;
      ndig <= '0;
    end
    if (state == S_MUL) begin
      prod <= cur[VALUE_W-1:1] * RECIP_31;
    end
    if (state == S_CORR) begin
      digits[ndig] <= r_fix;
      ndig         <= ndig + 1'b1;
      cur          <= q_fix;
    end
    if (state == S_CHECK) begin
      idx <= ndig - 1'b1;
    end
    if (state == S_DIGIT && slot_free && idx != '0) begin
      idx <= idx - 1'b1;
    end
    if (out_load) begin
      text_char <= char_next;
      last      <= last_next;
      overflow  <= ovf_next;
    end
  end

endmodule

>>> src/base62_integer_encoder_unit.sv
// Base-62 integer encoder top level: front end, queue and conversion back end.
// Each 32-bit signed input transaction yields its base-62 text, most significant
// digit first, with a leading '-' for negatives; the final character has last set.
// Results of two or more digits whose character count reaches buffer_length give
// a single transaction with overflow and last set and text_char zero instead.
// Each item passes through idle, then the reciprocal multiply and remainder
// correction loop once per digit, a capacity check, and one output step per
// character (the sign, then the digits), or a single error step on overflow.
// The queue holds further inputs while a conversion runs.
module base62_integer_encoder_unit #(
  parameter int QUEUE_DEPTH = b62e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  text_char,
  output logic        last,
  output logic        overflow
);
  import b62e_pkg::*;

  q_entry_t wr_entry;
  q_entry_t rd_entry;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  b62e_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .push     (push),
    .entry    (wr_entry),
    .full     (full)
  );

  b62e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_entry),
    .full    (full),
    .pop     (pop),
    .rd_data (rd_entry),
    .empty   (empty)
  );

  b62e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rd_data     (rd_entry),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .text_char   (text_char),
    .last        (last),
    .overflow    (overflow)
  );

endmodule

>>> src/b62e_checker.sv
// Port-level checker for the base-62 integer encoder, bound to the top level.
module b62e_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] value,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  text_char,
  input logic        last,
  input logic        overflow
);
  import b62e_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(value))
    else $error("input transaction changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(text_char) && $stable(last)
      && $stable(overflow))
    else $error("output transaction changed while stalled");

  a_ovf_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> last && text_char == CHAR_NUL)
    else $error("overflow transaction malformed");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_char == CHAR_MINUS |-> !last && !overflow)
    else $error("sign character ended a conversion");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind base62_integer_encoder_unit b62e_checker u_b62e_checker (.*);
